FILE: hdl/sorted_list_deque_engine_top_defines.svh
// Assertion macros for the sorted list deque engine RTL (included by sldq_ctrl).
`ifndef SORTED_LIST_DEQUE_ENGINE_TOP_DEFINES_SVH
`define SORTED_LIST_DEQUE_ENGINE_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SLDQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SLDQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/sldq_pkg.sv
// Types, codes and sizes shared by the sorted list deque engine.
package sldq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_SORTED_INS = 3'd2;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [2:0] CMD_POP_BACK   = 3'd4;
	localparam logic [2:0] CMD_REMOVE     = 3'd5;
	localparam logic [2:0] CMD_READ_OUT   = 3'd6;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_EMPTY     = 2'd1;
	localparam logic [1:0] STS_NOT_FOUND = 2'd2;
	localparam logic [1:0] STS_FULL      = 2'd3;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic [1:0]         status;
		logic               last;
	} rsp_t;

	typedef enum logic [1:0] {
		SH_HOLD,
		SH_INS,
		SH_REM,
		SH_ROT
	} shift_t;

	typedef enum logic [2:0] {
		AP_ALL,
		AP_FREE,
		AP_TAIL,
		AP_GE,
		AP_EQ
	} apmode_t;

	typedef struct packed {
		shift_t             shift;
		apmode_t            mode;
		logic signed [31:0] value;
		logic signed [31:0] head;
	} ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

endpackage

FILE: hdl/sldq_cell.sv
// One list position: holds an entry and shifts with its neighbors.
module sldq_cell (
	input  logic               clk,
	input  sldq_pkg::ctl_t     ctl,
	input  logic               first,
	input  logic               valid,
	input  logic               valid_next,
	input  logic signed [31:0] e_prev,
	input  logic signed [31:0] e_next,
	input  logic               ap_prev,
	input  logic signed [31:0] pick_in,
	input  logic signed [31:0] tail_in,
	output logic signed [31:0] e,
	output logic               ap,
	output logic signed [31:0] pick_out,
	output logic signed [31:0] tail_out
);
	import sldq_pkg::*;

	logic signed [31:0] e_q;
	logic signed [31:0] e_d;

	always_comb begin
		unique case (ctl.mode)
			AP_ALL:  ap = 1'b1;
			AP_FREE: ap = !valid;
			AP_TAIL: ap = !valid_next;
			AP_GE:   ap = !first && (ap_prev || !valid || !(e_q < ctl.value));
			AP_EQ:   ap = !first && (ap_prev || (valid && (e_q == ctl.value)));
			default: ap = 1'b0;
		endcase
	end

	always_comb begin
		unique case (ctl.shift)
			SH_INS:  e_d = ap ? (ap_prev ? e_prev : ctl.value) : e_q;
			SH_REM:  e_d = ap ? e_next : e_q;
			SH_ROT:  e_d = valid ? (valid_next ? e_next : ctl.head) : e_q;
			default: e_d = e_q;
		endcase
	end

	always_ff @(posedge clk) begin
		e_q <= e_d;
	end

	assign e        = e_q;
	assign pick_out = pick_in | ((ap && !ap_prev) ? e_q : 32'sd0);
	assign tail_out = tail_in | ((valid && !valid_next) ? e_q : 32'sd0);

endmodule

FILE: hdl/sldq_ctrl.sv
// Command decode, list count, read-out sequencer and result register.
module sldq_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  sldq_pkg::req_t           req,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output sldq_pkg::rsp_t           rsp,
	input  logic signed [31:0]       head,
	input  logic signed [31:0]       tail,
	input  logic                     found,
	input  logic signed [31:0]       picked,
	output sldq_pkg::ctl_t           ctl,
	output logic [sldq_pkg::CNT_W-1:0] count
);
	import sldq_pkg::*;

	`include "sorted_list_deque_engine_top_defines.svh"

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   rem_q, rem_d;
	logic               rsp_valid_q;
	rsp_t               rsp_q, rsp_d;
	logic               load;
	logic               acc;
	logic               emit;
	logic               full;
	logic               empty;
	logic               is_push;

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign emit      = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign acc       = req_valid && !req_stall;
	assign is_push   = (req.cmd == CMD_PUSH_FRONT) || (req.cmd == CMD_PUSH_BACK)
		|| (req.cmd == CMD_SORTED_INS);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && (req.cmd == CMD_READ_OUT) && !empty)
					state_d = ST_READ;
			end
			ST_READ: begin
				if (emit && (rem_q == CNT_W'(1)))
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.shift = SH_HOLD;
		ctl.mode  = AP_ALL;
		ctl.value = req.value;
		ctl.head  = head;
		load      = 1'b0;
		rsp_d     = '{value_out: 32'sd0, status: STS_OK, last: 1'b1};
		count_d   = count_q;
		rem_d     = rem_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					load = 1'b1;
					if (is_push && full) begin
						rsp_d.status = STS_FULL;
					end else if (is_push) begin
						ctl.shift = SH_INS;
						count_d   = count_q + CNT_W'(1);
						if (req.cmd == CMD_PUSH_BACK)
							ctl.mode = AP_FREE;
						else if (req.cmd == CMD_SORTED_INS) begin
							if (empty || (req.value < head))
								ctl.mode = AP_ALL;
							else if (!(req.value < tail))
								ctl.mode = AP_FREE;
							else
								ctl.mode = AP_GE;
						end
					end else if (req.cmd == CMD_POP_FRONT || req.cmd == CMD_POP_BACK
						|| req.cmd == CMD_REMOVE || req.cmd == CMD_READ_OUT) begin
						if (empty) begin
							rsp_d.status = STS_EMPTY;
						end else if (req.cmd == CMD_READ_OUT) begin
							load  = 1'b0;
							rem_d = count_q;
						end else begin
							ctl.shift = SH_REM;
							if (req.cmd == CMD_POP_BACK)
								ctl.mode = AP_TAIL;
							else if (req.cmd == CMD_REMOVE) begin
								if (head == req.value)
									ctl.mode = AP_ALL;
								else if (tail == req.value)
									ctl.mode = AP_TAIL;
								else
									ctl.mode = AP_EQ;
							end
							if (ctl.mode != AP_EQ || found) begin
								rsp_d.value_out = picked;
								count_d         = count_q - CNT_W'(1);
							end else begin
								rsp_d.status = STS_NOT_FOUND;
							end
						end
					end else begin
						load = 1'b0;
					end
				end
			end
			ST_READ: begin
				if (emit) begin
					load            = 1'b1;
					ctl.shift       = SH_ROT;
					rsp_d.value_out = head;
					rsp_d.last      = (rem_q == CNT_W'(1));
					rem_d           = rem_q - CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign count     = count_q;

	`SLDQ_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`SLDQ_ASSERT_IMPL(a_read_rem, state_q == ST_READ,
		(rem_q != '0) && (rem_q <= count_q), "read-out counter out of range")
	`SLDQ_ASSERT_IMPL(a_not_last_in_read, rsp_valid_q && !rsp_q.last,
		state_q == ST_READ, "non-final result outside read-out")
	`SLDQ_ASSERT_NEXT(a_full_push_hold, acc && is_push && full,
		$stable(count_q), "push to full list changed count")

endmodule

FILE: hdl/sorted_list_deque_engine_top.sv
// Top level of the sorted list deque engine: control plus a row of list cells.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------
//  request | req_valid | req_stall | req (cmd, value)
//  result  | rsp_valid | rsp_stall | rsp (value_out, status, last)
//
// Push, insert, pop and remove commands: each cell compares and shifts in parallel,
// and the result register loads at the same edge as the cell storage.
// Read-out holds the request side from the accepting cycle until the last entry
// is out, one entry per cycle while not stalled, rotating the row of cells through the head.
// Reset clears the count and the handshake state; entry storage is not reset.
// A stalled result holds the register and blocks the next transaction.
module sorted_list_deque_engine_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sldq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sldq_pkg::rsp_t rsp
);
	import sldq_pkg::*;

	ctl_t               ctl;
	logic [CNT_W-1:0]   count;
	logic [CAPACITY:0]  vld;
	logic [CAPACITY:0]  ap_c;
	logic signed [31:0] e_c    [0:CAPACITY-1];
	logic signed [31:0] pick_c [0:CAPACITY];
	logic signed [31:0] tail_c [0:CAPACITY];

	assign ap_c[0]   = 1'b0;
	assign pick_c[0] = 32'sd0;
	assign tail_c[0] = 32'sd0;
	assign vld[CAPACITY] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] prev;
		logic signed [31:0] next;

		assign vld[i] = (count > CNT_W'(i));

		if (i == 0) begin : g_first
			assign prev = 32'sd0;
		end else begin : g_mid
			assign prev = e_c[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next = 32'sd0;
		end else begin : g_inner
			assign next = e_c[i+1];
		end

		sldq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.first      (i == 0),
			.valid      (vld[i]),
			.valid_next (vld[i+1]),
			.e_prev     (prev),
			.e_next     (next),
			.ap_prev    (ap_c[i]),
			.pick_in    (pick_c[i]),
			.tail_in    (tail_c[i]),
			.e          (e_c[i]),
			.ap         (ap_c[i+1]),
			.pick_out   (pick_c[i+1]),
			.tail_out   (tail_c[i+1])
		);
	end

	sldq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.head      (e_c[0]),
		.tail      (tail_c[CAPACITY]),
		.found     (ap_c[CAPACITY]),
		.picked    (pick_c[CAPACITY]),
		.ctl       (ctl),
		.count     (count)
	);

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the sorted list deque engine: directed table, then random traffic.
module tb;
	import sldq_pkg::*;

	localparam int          MAX_CYCLES = 1000000;
	localparam int          RAND_ITEMS = 500;
	localparam logic [2:0]  CMD_UNUSED = 3'd7;
	localparam logic signed [31:0] V_MIN = 32'sh80000000;
	localparam logic signed [31:0] V_MAX = 32'sh7fffffff;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] value;
		logic               typed;
		logic [1:0]         t_status;
	} row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_stall = 1'b0;
	req_t req       = '0;
	logic req_stall;
	logic rsp_valid;
	rsp_t rsp;

	logic signed [31:0] shadow_list[$];
	rsp_t               cmd_rsps[$];
	rsp_t               rsp_due_q[$];
	rsp_t               want;
	int                 errors = 0;
	int                 cycles = 0;
	bit                 quiet  = 1'b0;

	row_t dir_tab [0:22] = '{
		'{CMD_POP_FRONT,  32'sd0,         1'b1, STS_EMPTY},
		'{CMD_POP_BACK,   32'sd0,         1'b1, STS_EMPTY},
		'{CMD_REMOVE,     32'sd5,         1'b1, STS_EMPTY},
		'{CMD_READ_OUT,   32'sd0,         1'b1, STS_EMPTY},
		'{CMD_UNUSED,     32'sh55555555,  1'b0, STS_OK},
		'{CMD_SORTED_INS, 32'sd0,         1'b1, STS_OK},
		'{CMD_SORTED_INS, V_MAX,          1'b1, STS_OK},
		'{CMD_SORTED_INS, V_MIN,          1'b1, STS_OK},
		'{CMD_SORTED_INS, -32'sd1,        1'b1, STS_OK},
		'{CMD_SORTED_INS, 32'sd0,         1'b1, STS_OK},
		'{CMD_PUSH_FRONT, V_MAX,          1'b1, STS_OK},
		'{CMD_PUSH_BACK,  32'sd5,         1'b1, STS_OK},
		'{CMD_READ_OUT,   32'sd0,         1'b0, STS_OK},
		'{CMD_REMOVE,     32'sd5,         1'b0, STS_OK},
		'{CMD_REMOVE,     V_MAX,          1'b0, STS_OK},
		'{CMD_PUSH_BACK,  32'sd0,         1'b1, STS_OK},
		'{CMD_REMOVE,     32'sd0,         1'b0, STS_OK},
		'{CMD_REMOVE,     32'sd12345,     1'b1, STS_NOT_FOUND},
		'{CMD_REMOVE,     32'sd0,         1'b0, STS_OK},
		'{CMD_POP_FRONT,  32'sd0,         1'b0, STS_OK},
		'{CMD_POP_BACK,   32'sd0,         1'b0, STS_OK},
		'{CMD_READ_OUT,   32'sd0,         1'b0, STS_OK},
		'{CMD_UNUSED,     32'shaaaaaaaa,  1'b0, STS_OK}
	};

	sorted_list_deque_engine_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= MAX_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int idle_cycles();
		if (quiet)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	function automatic void apply_cmd(input req_t r);
		rsp_t o;
		int   pos;
		cmd_rsps.delete();
		o      = '0;
		o.last = 1'b1;
		case (r.cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_SORTED_INS: begin
				if (shadow_list.size() >= CAPACITY) begin
					o.status = STS_FULL;
				end else begin
					if (r.cmd == CMD_PUSH_FRONT)
						pos = 0;
					else if (r.cmd == CMD_PUSH_BACK)
						pos = shadow_list.size();
					else if (shadow_list.size() == 0 || r.value < shadow_list[0])
						pos = 0;
					else if (r.value >= shadow_list[$])
						pos = shadow_list.size();
					else begin
						pos = 1;
						while (pos < shadow_list.size() && shadow_list[pos] < r.value)
							pos++;
					end
					shadow_list.insert(pos, r.value);
					o.status = STS_OK;
				end
				cmd_rsps.push_back(o);
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (shadow_list.size() == 0)
					o.status = STS_EMPTY;
				else if (r.cmd == CMD_POP_FRONT)
					o.value_out = shadow_list.pop_front();
				else
					o.value_out = shadow_list.pop_back();
				cmd_rsps.push_back(o);
			end
			CMD_REMOVE: begin
				if (shadow_list.size() == 0) begin
					o.status = STS_EMPTY;
				end else begin
					if (shadow_list[0] == r.value)
						pos = 0;
					else if (shadow_list[$] == r.value)
						pos = shadow_list.size() - 1;
					else begin
						pos = 1;
						while (pos < shadow_list.size() && shadow_list[pos] != r.value)
							pos++;
					end
					if (pos >= shadow_list.size()) begin
						o.status = STS_NOT_FOUND;
					end else begin
						o.value_out = shadow_list[pos];
						shadow_list.delete(pos);
					end
				end
				cmd_rsps.push_back(o);
			end
			CMD_READ_OUT: begin
				if (shadow_list.size() == 0) begin
					o.status = STS_EMPTY;
					cmd_rsps.push_back(o);
				end else begin
					foreach (shadow_list[i]) begin
						o.value_out = shadow_list[i];
						o.last      = (i == shadow_list.size() - 1);
						cmd_rsps.push_back(o);
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0, 1, 2: return int'($urandom_range(0, 16)) - 8;
			3: begin
				case ($urandom_range(0, 3))
					0: return V_MIN;
					1: return V_MAX;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			4: begin
				if (shadow_list.size() > 0)
					return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
				return $urandom;
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t rand_item(input int mode);
		req_t r;
		int   pick;
		int   push_pct;
		push_pct = (mode == 0) ? 80 : (mode == 1) ? 15 : 45;
		pick     = $urandom_range(0, 99);
		r.value  = pick_value();
		if (pick < push_pct)
			r.cmd = 3'($urandom_range(0, 2));
		else if (pick < push_pct + 8)
			r.cmd = CMD_READ_OUT;
		else if (pick < push_pct + 10)
			r.cmd = CMD_UNUSED;
		else
			r.cmd = 3'($urandom_range(3, 5));
		if (r.cmd == CMD_REMOVE && shadow_list.size() > 0 && $urandom_range(0, 3) != 0)
			r.value = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
		return r;
	endfunction

	task automatic issue_cmd(input req_t r, input logic typed, input logic [1:0] t_status);
		int   gap;
		rsp_t t;
		gap = idle_cycles();
		@(negedge clk);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       = r;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		apply_cmd(r);
		if (typed) begin
			t.value_out = '0;
			t.status    = t_status;
			t.last      = 1'b1;
			rsp_due_q.push_back(t);
		end else begin
			foreach (cmd_rsps[i])
				rsp_due_q.push_back(cmd_rsps[i]);
		end
	endtask

	initial begin
		int n;
		forever begin
			n = idle_cycles();
			@(negedge clk);
			if (n > 0) begin
				rsp_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			rsp_stall = 1'b0;
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due_q.size() == 0) begin
				$display("%0t unexpected result: value_out %0d status %0d last %0d",
					$time, rsp.value_out, rsp.status, rsp.last);
				errors++;
			end else begin
				want = rsp_due_q.pop_front();
				if (rsp.value_out !== want.value_out) begin
					$display("%0t value_out mismatch: expected %0d, actual %0d",
						$time, want.value_out, rsp.value_out);
					errors++;
				end
				if (rsp.status !== want.status) begin
					$display("%0t status mismatch: expected %0d, actual %0d",
						$time, want.status, rsp.status);
					errors++;
				end
				if (rsp.last !== want.last) begin
					$display("%0t last mismatch: expected %0d, actual %0d",
						$time, want.last, rsp.last);
					errors++;
				end
			end
		end
	end

	initial begin
		req_t r;
		int   done;
		int   mode;
		int   plen;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			r.cmd   = dir_tab[i].cmd;
			r.value = dir_tab[i].value;
			issue_cmd(r, dir_tab[i].typed, dir_tab[i].t_status);
		end

		// fill first so the full-list path is reached early
		done = 0;
		mode = 0;
		plen = 40;
		while (done < RAND_ITEMS) begin
			repeat (plen) begin
				r = rand_item(mode);
				issue_cmd(r, 1'b0, STS_OK);
				if (r.cmd != CMD_UNUSED)
					done++;
			end
			mode  = $urandom_range(0, 2);
			plen  = $urandom_range(20, 60);
			quiet = ($urandom_range(0, 3) == 0);
		end

		@(negedge clk);
		req_valid = 1'b0;
		quiet     = 1'b1;
		while (rsp_due_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sorted_list_deque_engine_top.f
+incdir+hdl
hdl/sldq_pkg.sv
hdl/sldq_cell.sv
hdl/sldq_ctrl.sv
hdl/sorted_list_deque_engine_top.sv
tb/tb.sv
